>>> design/dqs_pkg.sv
// shared codes and types for the deque with search unit
// no dependencies; imported by dqs_cell and deque_with_search_unit
package dqs_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int KIND_W = 3;
    localparam int MODE_W = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

    localparam logic [KIND_W-1:0] KIND_SEARCH_EMPTY = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FOUND        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ELEMENT      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP_EMPTY   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PUSH_FULL    = 3'd5;

    localparam logic [MODE_W-1:0] MODE_HOLD       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROTATE     = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] front;
    } t_cell_ctl;

endpackage

>>> design/dqs_cell.sv
// one slot of the shifting deque chain, with its own search comparator
// depends on dqs_pkg
module dqs_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                        i_clk,
    input  dqs_pkg::t_cell_ctl          i_ctl,
    input  logic [CNT_W-1:0]            i_count,
    input  logic signed [31:0]          i_left,
    input  logic signed [31:0]          i_right,
    output logic signed [31:0]          o_data,
    output logic                        o_hit
);
    import dqs_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_hit;
    logic                     w_occupied;
    logic                     w_is_back;

    assign w_occupied = CNT_W'(IDX) < i_count;
    assign w_is_back  = CNT_W'(IDX + 1) == i_count;

    always_comb begin
        n_data = r_data;
        case (i_ctl.mode)
            MODE_PUSH_FRONT: n_data = (IDX == 0) ? i_ctl.value : i_left;
            MODE_PUSH_BACK:  n_data = (CNT_W'(IDX) == i_count) ? i_ctl.value : r_data;
            MODE_POP_FRONT:  n_data = i_right;
            MODE_ROTATE:     n_data = w_is_back ? i_ctl.front : i_right;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.mode == MODE_SEARCH) begin
            r_hit <= w_occupied && (r_data == i_ctl.value);
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

>>> design/deque_with_search_unit.sv
// top level of the bounded deque with search: control, count and cell chain
// depends on dqs_pkg and dqs_cell
//
//  channel  | handshake            | fields
//  ---------+----------------------+---------------------------------------------
//  command  | start, busy          | i_cmd, i_item_value
//  result   | o_strobe (one cycle) | o_reply_kind, o_element_value, o_last_of_run
//
// push and pop complete without leaving the idle state, busy stays low
// search compares in every cell, then or-reduces the hits
// dump first moves from idle into its dump state, then gives one element per cycle as the chain rotates through cell 0
// results are registered and show in the cycle after the one that makes them; the receiver cannot stall
// synchronous active-low reset empties the queue; cell contents are not cleared
module deque_with_search_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_cmd,
    input  logic signed [31:0]          i_item_value,
    output logic                        o_strobe,
    output logic [2:0]                  o_reply_kind,
    output logic signed [31:0]          o_element_value,
    output logic                        o_last_of_run
);
    import dqs_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DUMP   = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_left, n_left;
    logic                     r_strobe, n_strobe;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic signed [DATA_W-1:0] r_elem, n_elem;
    logic                     r_last, n_last;

    t_cell_ctl                w_ctl;
    logic [MODE_W-1:0]        w_mode;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]      w_hit;
    logic                     w_full;
    logic                     w_empty;

    assign w_full  = r_count == CNT_W'(CAPACITY);
    assign w_empty = r_count == '0;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_kind   = r_kind;
        n_elem   = r_elem;
        n_last   = r_last;
        w_mode   = MODE_HOLD;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (w_full) begin
                                n_strobe = 1'b1;
                                n_kind   = KIND_PUSH_FULL;
                                n_elem   = '0;
                                n_last   = 1'b1;
                            end else begin
                                w_mode  = (i_cmd == CMD_PUSH_FRONT) ? MODE_PUSH_FRONT
                                                                    : MODE_PUSH_BACK;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (!w_empty) begin
                                w_mode  = MODE_POP_FRONT;
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (!w_empty) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_kind   = KIND_SEARCH_EMPTY;
                                n_elem   = '0;
                                n_last   = 1'b1;
                            end else begin
                                w_mode  = MODE_SEARCH;
                                n_state = ST_SEARCH;
                            end
                        end
                        CMD_DUMP: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_kind   = KIND_DUMP_EMPTY;
                                n_elem   = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_left  = r_count;
                                n_state = ST_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                n_strobe = 1'b1;
                n_kind   = (|w_hit) ? KIND_FOUND : KIND_NOT_FOUND;
                n_elem   = '0;
                n_last   = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_DUMP: begin
                w_mode   = MODE_ROTATE;
                n_strobe = 1'b1;
                n_kind   = KIND_ELEMENT;
                n_elem   = w_data[0];
                n_last   = r_left == CNT_W'(1);
                n_left   = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_ctl.mode  = w_mode;
    assign w_ctl.value = i_item_value;
    assign w_ctl.front = w_data[0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dqs_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_left  ((g == 0) ? i_item_value : w_data[(g == 0) ? 0 : g - 1]),
            .i_right (w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data  (w_data[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
        r_kind <= n_kind;
        r_elem <= n_elem;
        r_last <= n_last;
    end

    assign busy            = r_state != ST_IDLE;
    assign o_strobe        = r_strobe;
    assign o_reply_kind    = r_kind;
    assign o_element_value = r_elem;
    assign o_last_of_run   = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_reply_kind != KIND_ELEMENT) |-> (o_last_of_run && o_element_value == '0))
        else $error("single reply not marked last or carries data");

    a_search_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |=> (o_strobe && (o_reply_kind == KIND_FOUND
                                                 || o_reply_kind == KIND_NOT_FOUND)))
        else $error("search compare gave no reply");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP && r_left == CNT_W'(1)) |=> (o_last_of_run && !busy))
        else $error("dump run did not end on its last element");

endmodule
